// ===== rtl/bba_pkg.sv =====
package bba_pkg;

  // request codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // result status codes
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  localparam int WORD_BITS = 64;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_SCAN_WAIT,
    S_FULL_CHECK,
    S_FULL_WAIT,
    S_FREE_READ,
    S_FREE_WAIT,
    S_EMPTY_CHECK,
    S_EMPTY_WAIT,
    S_DONE
  } state_t;

  // lowest clear bit of a word, 64 when all ones
  function automatic logic [6:0] first_zero(input logic [63:0] v);
    logic [6:0] r;
    r = 7'd64;
    for (int i = 63; i >= 0; i--) begin
      if (!v[i]) r = 7'(i);
    end
    return r;
  endfunction

endpackage

// ===== rtl/bitmap_block_allocator.sv =====
// channel | dir | tdata (low bit up)      | tuser  | handshake
// s_axis  | in  | block_number[11:0]      | action | s_axis_tvalid/tready
// m_axis  | out | granted_block[11:0]     | status | m_axis_tvalid/tready
// one request at a time, set by the one-read-per-cycle bitmap memory (W words a page);
// a failed allocate goes straight to the result; an allocate scans the page for a
// clear bit and then runs the full check, a page opening first clears its W words;
// a free reads the word and, if the bit is set, clears it and runs the empty check
// rst is synchronous; the bitmap memory needs no clearing pass, pages are cleared
// when opened and a free to a page never opened is dropped before any read
// the output register holds a stalled result while the next request runs;
// the sequencer waits in done only while that register is still full
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int PAGES = 8,
  parameter int BLOCKS_PER_PAGE = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // block_number
  input  logic        s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // granted_block
  output logic        m_axis_tuser   // status
);

  localparam int WPP   = BLOCKS_PER_PAGE / WORD_BITS;
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int WW    = (WPP > 1) ? $clog2(WPP) : 1;
  localparam int DEPTH = PAGES * WPP;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(PAGES + 1);
  localparam int OFFW  = $clog2(BLOCKS_PER_PAGE);

  // bitmap memory
  logic [63:0] mem [DEPTH];
  logic [63:0] rdata;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [63:0]   wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // list and fifo state
  logic [PW-1:0] pnext [PAGES];
  logic [PW-1:0] pprev [PAGES];
  logic [PAGES-1:0] listed;
  logic [PW-1:0] head, tail;
  logic [CW-1:0] pcount;
  logic [PW-1:0] fifo [PAGES];
  logic [PW-1:0] fhead;
  logic [CW-1:0] fcount;
  logic [CW-1:0] opened;

  state_t state, state_next;
  logic [5:0]    blk;
  logic [PW-1:0] page;
  logic [WW-1:0] widx;
  logic          res_status;
  logic [11:0]   res_block;
  logic          ovalid;
  logic          out_status;
  logic [11:0]   out_block;

  logic in_xfer, out_xfer;
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata  = {4'd0, out_block};
  assign m_axis_tuser  = out_status;

  logic [6:0] fz;
  assign fz = first_zero(rdata);
  logic last_w;
  assign last_w = (widx == WW'(WPP - 1));

  logic [AW-1:0] cur_addr;
  assign cur_addr = AW'(page) * AW'(WPP) + AW'(widx);

  // decode of the free request, only opened pages can hold set bits
  logic [11:0] in_page;
  logic        free_ok;
  assign in_page = s_axis_tdata[11:0] >> OFFW;
  assign free_ok = (in_page < 12'(opened));
  logic [5:0]    fr_bit;
  assign fr_bit  = blk;

  // fifo push slot, wrapped without a divider
  logic [CW:0]   fsum;
  logic [PW-1:0] fpush;
  assign fsum  = (CW+1)'(fhead) + (CW+1)'(fcount);
  assign fpush = PW'((fsum >= (CW+1)'(PAGES)) ? fsum - (CW+1)'(PAGES) : fsum);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_xfer) begin
        if (s_axis_tuser == ACT_FREE) begin
          state_next = free_ok ? S_FREE_READ : S_DONE;
        end else if (pcount != '0) begin
          state_next = S_SCAN;
        end else if (fcount != '0 || opened < CW'(PAGES)) begin
          state_next = S_CLEAR;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CLEAR:       if (last_w) state_next = S_SCAN;
      S_SCAN:        state_next = S_SCAN_WAIT;
      S_SCAN_WAIT:   if (fz != 7'd64) state_next = S_FULL_CHECK;
                     else if (last_w) state_next = S_DONE;
                     else state_next = S_SCAN;
      S_FULL_CHECK:  state_next = S_FULL_WAIT;
      S_FULL_WAIT:   if (rdata != '1 || last_w) state_next = S_DONE;
                     else state_next = S_FULL_CHECK;
      S_FREE_READ:   state_next = S_FREE_WAIT;
      S_FREE_WAIT:   state_next = rdata[fr_bit] ? S_EMPTY_CHECK : S_DONE;
      S_EMPTY_CHECK: state_next = S_EMPTY_WAIT;
      S_EMPTY_WAIT:  if (rdata != '0 || last_w) state_next = S_DONE;
                     else state_next = S_EMPTY_CHECK;
      S_DONE:        if (!ovalid || out_xfer) state_next = S_IDLE;
      default:       state_next = S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    raddr = cur_addr;
    we    = 1'b0;
    waddr = cur_addr;
    wdata = '0;
    case (state)
      S_CLEAR: we = 1'b1;
      S_SCAN_WAIT: if (fz != 7'd64) begin
        we = 1'b1;
        wdata = rdata | (64'd1 << fz[5:0]);
      end
      S_FREE_WAIT: if (rdata[fr_bit]) begin
        we = 1'b1;
        wdata = rdata & ~(64'd1 << fr_bit);
      end
      default: we = 1'b0;
    endcase
  end

  // list append and remove helpers through next values
  logic [PW-1:0] head_next, tail_next;
  logic [CW-1:0] pcount_next;
  logic [PAGES-1:0] listed_next;
  logic [PW-1:0] pnext_next [PAGES];
  logic [PW-1:0] pprev_next [PAGES];
  logic do_append, do_remove;
  logic [PW-1:0] ap_page, rm_page;

  always_comb begin
    logic [PW-1:0] a, b;
    a = '0;
    b = '0;
    head_next = head;
    tail_next = tail;
    pcount_next = pcount;
    listed_next = listed;
    pnext_next = pnext;
    pprev_next = pprev;
    if (do_append) begin
      if (pcount == '0) head_next = ap_page;
      else begin
        pnext_next[tail] = ap_page;
        pprev_next[ap_page] = tail;
      end
      tail_next = ap_page;
      listed_next[ap_page] = 1'b1;
      pcount_next = pcount + 1'b1;
    end
    if (do_remove) begin
      a = pprev_next[rm_page];
      b = pnext_next[rm_page];
      if (rm_page == head_next) head_next = b;
      else pnext_next[a] = b;
      if (rm_page == tail_next) tail_next = a;
      else pprev_next[b] = a;
      listed_next[rm_page] = 1'b0;
      if (pcount_next != '0) pcount_next = pcount_next - 1'b1;
    end
  end

  // list operations per state
  always_comb begin
    do_append = 1'b0;
    do_remove = 1'b0;
    ap_page = page;
    rm_page = page;
    case (state)
      S_CLEAR:      do_append = last_w;
      S_FULL_WAIT:  do_remove = (rdata == '1) && last_w;
      S_FREE_WAIT:  do_append = rdata[fr_bit] && !listed[page];
      S_EMPTY_WAIT: do_remove = (rdata == '0) && last_w;
      default:      do_append = 1'b0;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      tail   <= '0;
      pcount <= '0;
      listed <= '0;
      fhead  <= '0;
      fcount <= '0;
      opened <= '0;
      ovalid <= 1'b0;
      for (int i = 0; i < PAGES; i++) begin
        pnext[i] <= '0;
        pprev[i] <= '0;
      end
    end else begin
      state  <= state_next;
      head   <= head_next;
      tail   <= tail_next;
      pcount <= pcount_next;
      listed <= listed_next;
      pnext  <= pnext_next;
      pprev  <= pprev_next;
      if (out_xfer) ovalid <= 1'b0;
      if (state == S_DONE && (!ovalid || out_xfer)) ovalid <= 1'b1;
      case (state)
        S_IDLE: if (in_xfer && s_axis_tuser == ACT_ALLOC && pcount == '0) begin
          if (fcount != '0) begin
            fhead  <= (fhead == PW'(PAGES - 1)) ? '0 : fhead + 1'b1;
            fcount <= fcount - 1'b1;
          end else if (opened < CW'(PAGES)) begin
            opened <= opened + 1'b1;
          end
        end
        S_EMPTY_WAIT: if (rdata == '0 && last_w) begin
          fifo[fpush] <= page;
          if (fcount < CW'(PAGES)) fcount <= fcount + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (in_xfer) begin
        blk  <= s_axis_tdata[5:0];
        widx <= '0;
        res_status <= ST_OK;
        res_block  <= '0;
        if (s_axis_tuser == ACT_FREE) begin
          page <= PW'(in_page);
          widx <= WW'(s_axis_tdata[OFFW-1:0] >> 6);
        end else if (pcount != '0) begin
          page <= head;
        end else if (fcount != '0) begin
          page <= fifo[fhead];
        end else if (opened < CW'(PAGES)) begin
          page <= PW'(opened);
        end else begin
          res_status <= ST_FAIL;
        end
      end
      S_CLEAR: widx <= last_w ? '0 : widx + 1'b1;
      S_SCAN_WAIT: begin
        if (fz != 7'd64) begin
          res_block <= 12'(32'(page) * BLOCKS_PER_PAGE + 32'(widx) * 64 + 32'(fz));
          widx <= '0;
        end else if (last_w) begin
          res_status <= ST_FAIL;
        end else begin
          widx <= widx + 1'b1;
        end
      end
      S_FULL_WAIT:  widx <= widx + 1'b1;
      S_FREE_WAIT:  widx <= '0;
      S_EMPTY_WAIT: widx <= widx + 1'b1;
      default: ;
    endcase
  end

  // output register, loaded when the finished result can move in
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!ovalid || out_xfer)) begin
      out_status <= res_status;
      out_block  <= res_block;
    end
  end

`ifndef SYNTHESIS
  // counts never pass the page count
  a_pcount: assert property (@(posedge clk) disable iff (rst) pcount <= CW'(PAGES))
    else $error("partial count overflow");
  a_fcount: assert property (@(posedge clk) disable iff (rst) fcount <= CW'(PAGES))
    else $error("fifo count overflow");
  // a stalled result holds steady
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");
  // a failed result carries no block
  a_fail: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == ST_FAIL) |-> m_axis_tdata[11:0] == 12'd0)
    else $error("failed allocate carries a block");
`endif

endmodule
